@@ hw/rtl/mf3_pkg.sv @@
// Shared constants and types of the 3x3 median filter.
package mf3_pkg;

    localparam int PIX_W          = 8;
    localparam int COORD_W        = 10;
    localparam int CFG_W          = 11;
    localparam int WIN_N          = 9;
    localparam int MEDIAN_IDX     = WIN_N / 2;
    localparam int MIN_WIDTH      = 3;
    localparam int LINE_WIDTH_RST = 640;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // One pixel leaving the counter stage toward the line store.
    typedef struct packed {
        logic [PIX_W-1:0]   px;
        logic               emit;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_pix;

    // One window travelling down the sort chain.
    typedef struct packed {
        logic [WIN_N-1:0][PIX_W-1:0] px;
        logic [COORD_W-1:0]          row;
        logic [COORD_W-1:0]          col;
    } t_win;

endpackage

@@ hw/rtl/mf3_if.sv @@
// Request channels of the median filter: pixel input and median output.
interface mf3_in_if import mf3_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface mf3_out_if import mf3_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   median_value;
    logic [COORD_W-1:0] center_row;
    logic [COORD_W-1:0] center_col;

    modport source (output valid, output median_value, output center_row,
                    output center_col, input ready);
    modport sink   (input valid, input median_value, input center_row,
                    input center_col, output ready);
endinterface

@@ hw/rtl/mf3_line.sv @@
// Line store of the two previous rows and the 3x3 window register.
module mf3_line import mf3_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_addr,
    input  t_pix                         i_pix,
    output logic                         o_ready,
    output logic                         o_valid,
    input  logic                         i_ready,
    output t_win                         o_win
);

    localparam int AW = $clog2(MAX_WIDTH);

    // word: [2*PIX_W-1:PIX_W] row r-2, [PIX_W-1:0] row r-1
    logic [2*PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd;
    logic [2*PIX_W-1:0] r_fwd;
    logic               r_hit;
    logic               r_s1_valid;
    t_pix               r_s1;
    logic [AW-1:0]      r_addr;
    logic [WIN_N-1:0][PIX_W-1:0] r_win;

    logic [2*PIX_W-1:0] word;
    logic [2*PIX_W-1:0] wr_word;
    logic               leave;
    logic [WIN_N-1:0][PIX_W-1:0] n_win;

    assign leave   = r_s1_valid && i_ready;
    assign o_ready = !r_s1_valid || i_ready;
    assign o_valid = r_s1_valid && r_s1.emit;

    // take the word just written when the read raced the write
    assign word    = r_hit ? r_fwd : r_rd;
    assign wr_word = {word[PIX_W-1:0], r_s1.px};

    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = word[2*PIX_W-1:PIX_W];
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = word[PIX_W-1:0];
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_s1.px;
    end

    assign o_win.px  = n_win;
    assign o_win.row = r_s1.row;
    assign o_win.col = r_s1.col;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rd <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (leave) begin
            r_mem[r_addr] <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hit  <= leave && (r_addr == i_addr);
            r_fwd  <= wr_word;
            r_s1   <= i_pix;
            r_addr <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_win      <= '0;
        end else begin
            if (i_load) begin
                r_s1_valid <= 1'b1;
            end else if (leave) begin
                r_s1_valid <= 1'b0;
            end
            if (leave) begin
                r_win <= n_win;
            end
        end
    end

endmodule

@@ hw/rtl/mf3_cell.sv @@
// One odd-even transposition step of the window sort chain.
module mf3_cell import mf3_pkg::*; #(
    parameter int PHASE = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_win i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_win o_data
);

    logic r_valid;
    t_win r_data;
    t_win n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // swap each out-of-order neighbor pair of this phase
    always_comb begin
        n_data = i_data;
        for (int k = PHASE; k + 1 < WIN_N; k += 2) begin
            if (i_data.px[k] > i_data.px[k+1]) begin
                n_data.px[k]   = i_data.px[k+1];
                n_data.px[k+1] = i_data.px[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

endmodule

@@ hw/rtl/median_filter_3x3_top.sv @@
// Top level of the 3x3 median filter: counters, line store, sort chain.
//
// Takes one 8-bit pixel per clock in raster order and returns, for every
// pixel at row r and column c with r >= 2 and c >= 2, the median of the
// 3x3 window centred at (r-1, c-1) together with that centre's coordinates;
// border centres give no result. A request is taken every cycle (one pixel
// per clock sustained) as long as the result side keeps up; each stage
// holds only when the stage after it is full and stalled, so bubbles are
// squeezed out. A pixel is registered in the line store stage, whose
// memory does one read and one write per cycle, and its window then in
// each of the nine cells of an odd-even transposition sort, one compare
// step per cell. The line store is not cleared after reset; the first two
// rows of a frame fill it before any window that uses it is emitted.
// line_width is saturated to [3, MAX_WIDTH] when written and should be
// changed only between frames.
module median_filter_3x3_top import mf3_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    mf3_in_if.sink           i_pix,
    mf3_out_if.source        o_med
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int CW     = (WID_W > CFG_W) ? WID_W : CFG_W;
    localparam int RST_WD = (LINE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : LINE_WIDTH_RST;

    // Configuration: keep the index of the last column of a row.
    logic [COL_W-1:0] r_last_col;
    logic [COL_W-1:0] n_last_col;
    logic [CW-1:0]    cfg_ext;
    logic [CW-1:0]    cfg_sat;

    always_comb begin
        cfg_ext = CW'(i_cfg_wr_data);
        if (cfg_ext < CW'(MIN_WIDTH)) begin
            cfg_sat = CW'(MIN_WIDTH);
        end else if (cfg_ext > CW'(MAX_WIDTH)) begin
            cfg_sat = CW'(MAX_WIDTH);
        end else begin
            cfg_sat = cfg_ext;
        end
        n_last_col = COL_W'(cfg_sat - CW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= COL_W'(RST_WD - 1);
        end else if (i_cfg_wr_en) begin
            r_last_col <= n_last_col;
        end
    end

    // Raster counters: advance on every accepted request.
    logic             acc;
    logic             line_ready;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    t_pix             pix;

    assign i_pix.ready = line_ready;
    assign acc         = i_pix.valid && line_ready;

    always_comb begin
        // frame start restarts this very pixel at the origin
        cur_col  = i_pix.frame_start ? '0 : r_col;
        cur_row  = i_pix.frame_start ? '0 : r_row;
        pix.px   = i_pix.pixel;
        pix.emit = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
        pix.row  = COORD_W'(cur_row - ROW_W'(1));
        pix.col  = COORD_W'(cur_col - COL_W'(1));
        if (cur_col >= r_last_col) begin
            n_col = '0;
            n_row = (cur_row == ROW_W'(MAX_HEIGHT - 1)) ? '0 : cur_row + ROW_W'(1);
        end else begin
            n_col = cur_col + COL_W'(1);
            n_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line store and window: hand each completed window to the sort chain.
    logic [WIN_N:0] w_valid;
    logic [WIN_N:0] w_ready;
    t_win           w_data [WIN_N+1];

    mf3_line #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (acc),
        .i_addr  (cur_col),
        .i_pix   (pix),
        .o_ready (line_ready),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_win   (w_data[0])
    );

    // Sort chain: nine alternating compare steps fully order the window.
    for (genvar g = 0; g < WIN_N; g++) begin : g_cell
        mf3_cell #(
            .PHASE (g % 2)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    // Last cell is the output register: take the middle element.
    assign w_ready[WIN_N]     = o_med.ready;
    assign o_med.valid        = w_valid[WIN_N];
    assign o_med.median_value = w_data[WIN_N].px[MEDIAN_IDX];
    assign o_med.center_row   = w_data[WIN_N].row;
    assign o_med.center_col   = w_data[WIN_N].col;

    // A frame start puts the next pixel at column one of row zero.
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_pix.frame_start |=> r_col == COL_W'(1) && r_row == '0)
        else $error("counters not restarted by frame start");

    // Input stalls only when the whole chain is backed up from the output.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> o_med.valid && !o_med.ready)
        else $error("input stalled without output backpressure");

    // The window at the output is ordered around its middle.
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_med.valid |-> w_data[WIN_N].px[MEDIAN_IDX-1] <= w_data[WIN_N].px[MEDIAN_IDX]
                     && w_data[WIN_N].px[MEDIAN_IDX] <= w_data[WIN_N].px[MEDIAN_IDX+1])
        else $error("sort chain output not ordered");

endmodule
